// ===== design/incremental_pid_with_clamp_macros.svh =====
// Assertion macros shared by the incremental PID checker.
`ifndef INCREMENTAL_PID_WITH_CLAMP_MACROS_SVH
`define INCREMENTAL_PID_WITH_CLAMP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define IPID_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("incremental PID check failed");

// Next-cycle implication, disabled while reset is asserted
`define IPID_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("incremental PID check failed");

// Next-cycle implication that also holds through reset
`define IPID_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("incremental PID check failed");

`endif

// ===== design/ipid_pkg.sv =====
// Widths, register indexes and law codes of the incremental PID block.
package ipid_pkg;

  // Sample and gain formats
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_FRAC = 8;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = SAMPLE_W - 1;

  // Internal arithmetic widths
  localparam int ERR_W  = SAMPLE_W + 1;          // ref - fdb
  localparam int D1_W   = SAMPLE_W + 2;          // e - e1
  localparam int D2_W   = SAMPLE_W + 3;          // e - 2*e1 + e0
  localparam int PROD_W = GAIN_W + 1 + D2_W;     // gain times a difference
  localparam int SUM_W  = PROD_W + 3;            // accumulator plus three products
  localparam int ACC_W  = SAMPLE_W + GAIN_FRAC + 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W   = ((2 * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SAMPLE_W + ERR_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = (GAIN_W > LIMIT_W) ? GAIN_W : LIMIT_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_DRIVE_LIMIT,
    REG_DRIVE_FLOOR,
    REG_LAW_SELECT
  } cfg_reg_t;

  // Control law codes
  localparam logic LAW_PID  = 1'b0;
  localparam logic LAW_PROP = 1'b1;

endpackage

// ===== design/incremental_pid_with_clamp.sv =====
// Incremental PID controller with output clamp and a proportional deadzone law.
//
// Each input transfer carries a reference and a feedback sample; each one
// produces exactly one result with the new drive, the error and a clamp flag.
// The block takes one sample per clock while the output side is not stalled.
// That rate comes from the controller loop: the gain multipliers, the accumulator
// add and the clamp all close combinationally into the accumulator and
// error-history registers. Gains are unsigned Q8.8, the accumulator keeps 8
// fraction bits and drive is its integer part truncated toward zero. Law 0 is
// the velocity-form PID with saturation to +-drive_limit; law 1 is proportional
// only, clamped, then forced to zero below drive_floor, and leaves the error
// history alone. Reset clears the accumulator and the error history.
// Configuration must be written through the plain write port only while the
// block is idle; the block itself does not enforce this.
module incremental_pid_with_clamp (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ipid_pkg::IN_TDATA_W-1:0]  in_tdata,   // reference, feedback
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ipid_pkg::OUT_TDATA_W-1:0] out_tdata,  // drive, error_now, zero pad
  output logic                             out_tuser,  // clamped
  // configuration writes
  input  logic                             cfg_we,
  input  logic [ipid_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ipid_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ipid_pkg::*;

  localparam logic signed [ACC_W-1:0] FRAC_MASK = ACC_W'((1 << GAIN_FRAC) - 1);

  // Configuration registers
  logic [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic [LIMIT_W-1:0] drive_limit_r, drive_floor_r;
  logic               law_select_r;

  // Input stage
  logic                    s1_valid_r;
  logic signed [ERR_W-1:0] s1_err_r;
  logic signed [ERR_W-1:0] err_in;

  // Controller state
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ERR_W-1:0] err1_r, err2_r;

  // Result stage
  logic                    out_valid_r;
  logic [SAMPLE_W-1:0]     out_drive_r, drive_nxt;
  logic [ERR_W-1:0]        out_err_r;
  logic                    out_clamp_r, clamp_nxt;

  // Datapath
  logic signed [D1_W-1:0]     d1, p_opnd;
  logic signed [D2_W-1:0]     d2;
  logic signed [GAIN_W:0]     gp_s, gi_s, gd_s;
  logic signed [PROD_W-1:0]   prod_p, prod_i, prod_d;
  logic signed [SUM_W-1:0]    sum_pid, pre, lim_w, neg_lim, clip_v;
  logic                       over_hi, over_lo, dead_zero;
  logic signed [ACC_W-1:0]    clip_acc, mag, floor_w, biased, shifted;

  logic adv, in_xfer;

  // Handshake: the compute step advances when the result register is free
  assign adv        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || adv;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_clamp_r;
  assign out_tdata  = OUT_TDATA_W'({out_err_r, out_drive_r});

  // Error of the incoming sample pair
  assign err_in = ERR_W'($signed(in_tdata[SAMPLE_W-1:0])) -
                  ERR_W'($signed(in_tdata[2*SAMPLE_W-1:SAMPLE_W]));

  // Error differences
  assign d1 = D1_W'(s1_err_r) - D1_W'(err1_r);
  assign d2 = D2_W'(s1_err_r) - (D2_W'(err1_r) <<< 1) + D2_W'(err2_r);

  // Gains as non-negative signed operands
  assign gp_s = $signed({1'b0, gain_p_r});
  assign gi_s = $signed({1'b0, gain_i_r});
  assign gd_s = $signed({1'b0, gain_d_r});

  // The proportional multiplier sees e - e1 in PID mode and e in P mode
  assign p_opnd = (law_select_r == LAW_PROP) ? D1_W'(s1_err_r) : d1;
  assign prod_p = PROD_W'(gp_s) * PROD_W'(p_opnd);
  assign prod_i = PROD_W'(gi_s) * PROD_W'(s1_err_r);
  assign prod_d = PROD_W'(gd_s) * PROD_W'(d2);

  assign sum_pid = SUM_W'(acc_r) + SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
  assign pre     = (law_select_r == LAW_PROP) ? SUM_W'(prod_p) : sum_pid;

  // Saturation to +-drive_limit
  assign lim_w   = $signed(SUM_W'(drive_limit_r) << GAIN_FRAC);
  assign neg_lim = -lim_w;
  assign over_hi = pre > lim_w;
  assign over_lo = pre < neg_lim;
  assign clip_v  = over_hi ? lim_w : (over_lo ? neg_lim : pre);
  assign clip_acc  = ACC_W'(clip_v);
  assign clamp_nxt = over_hi || over_lo;

  // Deadzone in proportional mode
  assign mag       = clip_acc[ACC_W-1] ? -clip_acc : clip_acc;
  assign floor_w   = $signed(ACC_W'(drive_floor_r) << GAIN_FRAC);
  assign dead_zero = (law_select_r == LAW_PROP) && (mag < floor_w);
  assign acc_nxt   = dead_zero ? '0 : clip_acc;

  // Integer part, truncated toward zero
  assign biased    = acc_nxt + (acc_nxt[ACC_W-1] ? FRAC_MASK : '0);
  assign shifted   = biased >>> GAIN_FRAC;
  assign drive_nxt = shifted[SAMPLE_W-1:0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
      drive_limit_r <= '1;
      drive_floor_r <= '0;
      law_select_r  <= LAW_PID;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GAIN_P:      gain_p_r      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:      gain_i_r      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:      gain_d_r      <= cfg_wdata[GAIN_W-1:0];
        REG_DRIVE_LIMIT: drive_limit_r <= cfg_wdata[LIMIT_W-1:0];
        REG_DRIVE_FLOOR: drive_floor_r <= cfg_wdata[LIMIT_W-1:0];
        REG_LAW_SELECT:  law_select_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Valid flags and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      err1_r      <= '0;
      err2_r      <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (adv) begin
        acc_r <= acc_nxt;
        if (law_select_r == LAW_PID) begin
          err2_r <= err1_r;
          err1_r <= s1_err_r;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_err_r <= err_in;
    end
    if (adv) begin
      out_drive_r <= drive_nxt;
      out_err_r   <= s1_err_r;
      out_clamp_r <= clamp_nxt;
    end
  end

endmodule

// ===== design/ipid_checker.sv =====
// Port-level checks for the incremental PID block, bound to its top level.
`include "incremental_pid_with_clamp_macros.svh"

module ipid_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ipid_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);
  import ipid_pkg::*;

  localparam logic [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W - 1){1'b0}}};

  // Reset empties the result register
  `IPID_ASSERT_NEXT_ALWAYS(a_reset_empties, clk, !rst_n, !out_tvalid)

  // A stalled result keeps its transfer contents
  `IPID_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // With the result side free, the input side never stalls
  `IPID_ASSERT_NOW(a_no_false_stall, clk, rst_n, !out_tvalid || out_tready, in_tready)

  // Saturation is symmetric, so drive never reaches the most negative code
  `IPID_ASSERT_NOW(a_drive_range, clk, rst_n, out_tvalid, out_tdata[SAMPLE_W-1:0] != MOST_NEG)

endmodule

bind incremental_pid_with_clamp ipid_checker u_ipid_checker (.*);
